// ===== src/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
// Holds the result word layout and the framing constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

	// Framing constants
	localparam int unsigned MAX_PACKET_DEF = 4096;
	localparam int unsigned LEN_W          = 16;
	localparam int unsigned MAXLEN_W       = 13;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 13'd4096;
	localparam logic [LEN_W-1:0]    MIN_PACKET   = 16'd4;

	// Prefix byte counter codes
	localparam logic [1:0] PREFIX_NONE = 2'd0;
	localparam logic [1:0] PREFIX_HIGH = 2'd1;
	localparam logic [1:0] PREFIX_DONE = 2'd2;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_LEN_ERR = 2'd1,
		KIND_DROPPED = 2'd2
	} kind_t;

	// One result word
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       out_byte;
		logic             first_of_packet;
		logic             last_of_packet;
		logic [LEN_W-1:0] packet_length;
	} result_t;

	// Handshake between the core and the output stage
	typedef struct packed {
		logic load;
		logic free;
	} out_ctl_t;

endpackage

`default_nettype wire

// ===== src/lpd_in_stage.sv =====
// Input register stage of the deframer.
// Captures one stream byte and holds it until the core takes it; uses nothing else.
`timescale 1ns / 1ps
`default_nettype none

module lpd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// Stall while a held word cannot move on
	assign in_stall = valid_s1 && !advance;

	// Hold valid; load on accept, drop when consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload byte
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

`default_nettype wire

// ===== src/lpd_core.sv =====
// Framing state and per-byte decision logic of the deframer.
// Uses lpd_pkg for the result word, kinds and framing constants.
`timescale 1ns / 1ps
`default_nettype none

module lpd_core #(
	parameter int unsigned MAX_PACKET = lpd_pkg::MAX_PACKET_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lpd_pkg::MAXLEN_W-1:0]  cfg_wdata,
	input  wire logic                          valid_s1,
	input  wire logic [7:0]                    byte_s1,
	input  wire lpd_pkg::out_ctl_t             out_ctl_in,
	output logic                               advance,
	output logic                               load_out,
	output lpd_pkg::result_t                   res
);
	import lpd_pkg::*;

	localparam logic [LEN_W-1:0] PKT_LIMIT = LEN_W'(MAX_PACKET);

	logic [MAXLEN_W-1:0] max_length_q;
	logic [1:0]          prefix_q,   prefix_d;
	logic [7:0]          high_q,     high_d;
	logic [LEN_W-1:0]    expected_q, expected_d;
	logic [LEN_W-1:0]    received_q, received_d;
	logic                failed_q,   failed_d;
	logic                has_res;
	logic [LEN_W-1:0]    len;
	logic [LEN_W-1:0]    limit;
	logic [LEN_W-1:0]    recv_inc;
	logic [LEN_W-1:0]    max_ext;

	// Effective upper bound on the decoded length
	assign max_ext  = LEN_W'(max_length_q);
	assign limit    = (max_ext < PKT_LIMIT) ? max_ext : PKT_LIMIT;
	assign len      = {high_q, byte_s1};
	assign recv_inc = received_q + 1'b1;

	// Decide the result and the next framing state for the held byte
	always_comb begin
		prefix_d   = prefix_q;
		high_d     = high_q;
		expected_d = expected_q;
		received_d = received_q;
		failed_d   = failed_q;
		has_res    = 1'b0;
		res        = '0;
		res.kind   = KIND_PAYLOAD;
		if (failed_q) begin
			has_res  = 1'b1;
			res.kind = KIND_DROPPED;
		end else begin
			case (prefix_q)
				PREFIX_NONE: begin
					high_d   = byte_s1;
					prefix_d = PREFIX_HIGH;
				end
				PREFIX_HIGH: begin
					if (len < MIN_PACKET || len > limit) begin
						failed_d          = 1'b1;
						has_res           = 1'b1;
						res.kind          = KIND_LEN_ERR;
						res.packet_length = len;
					end else begin
						expected_d = len;
						received_d = '0;
						prefix_d   = PREFIX_DONE;
					end
				end
				default: begin
					has_res               = 1'b1;
					res.kind              = KIND_PAYLOAD;
					res.out_byte          = byte_s1;
					res.first_of_packet   = (received_q == '0);
					res.last_of_packet    = (recv_inc >= expected_q);
					res.packet_length     = expected_q;
					received_d            = recv_inc;
					if (recv_inc >= expected_q) begin
						prefix_d   = PREFIX_NONE;
						high_d     = '0;
						expected_d = '0;
						received_d = '0;
					end
				end
			endcase
		end
	end

	// Move on when there is no result or the output stage has room
	assign advance  = valid_s1 && (!has_res || out_ctl_in.free);
	assign load_out = advance && has_res;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAXLEN_RESET;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	// Framing state; advance only when the held byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q   <= PREFIX_NONE;
			high_q     <= '0;
			expected_q <= '0;
			received_q <= '0;
			failed_q   <= 1'b0;
		end else if (advance) begin
			prefix_q   <= prefix_d;
			high_q     <= high_d;
			expected_q <= expected_d;
			received_q <= received_d;
			failed_q   <= failed_d;
		end
	end

	// Failure is sticky
	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("failure flag cleared without reset");

	// A length error always leaves the block failed
	a_err_sets_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && res.kind == KIND_LEN_ERR) |=> failed_q)
		else $error("length error did not set the failure flag");

	// Inside a packet the count stays below the length
	a_recv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(prefix_q == PREFIX_DONE) |-> (received_q < expected_q))
		else $error("received count reached packet length inside a packet");

	// Counter never takes the unused code
	a_prefix_code: assert property (@(posedge clk) disable iff (!arst_n)
		prefix_q <= PREFIX_DONE)
		else $error("prefix counter out of range");

endmodule

`default_nettype wire

// ===== src/lpd_out_stage.sv =====
// Output register stage of the deframer.
// Holds one result word until the receiver takes it; uses lpd_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module lpd_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire lpd_pkg::result_t   res_in,
	output lpd_pkg::out_ctl_t       ctl,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output lpd_pkg::result_t        res_s2
);
	import lpd_pkg::*;

	// Room when empty or the held word leaves this cycle
	assign ctl.free = !out_valid || !out_stall;
	assign ctl.load = load;

	// Hold valid; set on load, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			res_s2 <= res_in;
		end
	end

endmodule

`default_nettype wire

// ===== src/length_prefixed_deframer.sv =====
// Top level of the length-prefixed deframer.
// Connects lpd_in_stage, lpd_core and lpd_out_stage; uses lpd_pkg.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    in_byte
//  result    out        out_valid / out_stall  kind, out_byte, first_of_packet,
//                                              last_of_packet, packet_length
//  config    in         cfg_we                 cfg_wdata (max_length)
//
// One byte per cycle while in_stall is low; a result is presented once its byte has
// passed the input register and the decision logic into the result register.
// Prefix bytes give no result and need no output room, unless their length is bad.
// Reset clears framing state and the failure flag, and sets max_length to 4096.
// A stall on the result side backs up through both registers to in_stall.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_deframer #(
	parameter int unsigned MAX_PACKET = lpd_pkg::MAX_PACKET_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lpd_pkg::MAXLEN_W-1:0]  cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    in_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         kind,
	output logic [7:0]                         out_byte,
	output logic                               first_of_packet,
	output logic                               last_of_packet,
	output logic [lpd_pkg::LEN_W-1:0]          packet_length
);
	import lpd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       load_out;
	out_ctl_t   out_ctl;
	result_t    res;
	result_t    res_s2;

	// Input register
	lpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Framing decision and state
	lpd_core #(
		.MAX_PACKET (MAX_PACKET)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1),
		.out_ctl_in (out_ctl),
		.advance    (advance),
		.load_out   (load_out),
		.res        (res)
	);

	// Result register
	lpd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_out),
		.res_in    (res),
		.ctl       (out_ctl),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_s2    (res_s2)
	);

	// Unpack the result word onto the ports
	assign kind            = res_s2.kind;
	assign out_byte        = res_s2.out_byte;
	assign first_of_packet = res_s2.first_of_packet;
	assign last_of_packet  = res_s2.last_of_packet;
	assign packet_length   = res_s2.packet_length;

endmodule

`default_nettype wire
